/* rtl/esva_pkg.sv */
package esva_pkg;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;
    localparam int DIV_NW = 36;
    localparam int DIV_DW = 24;

    localparam logic [1:0] CMD_BEGIN   = 2'd0;
    localparam logic [1:0] CMD_ANIMATE = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;

    localparam logic [2:0] CURVE_IN     = 3'd1;
    localparam logic [2:0] CURVE_OUT    = 3'd2;
    localparam logic [2:0] CURVE_INOUT  = 3'd3;
    localparam logic [2:0] CURVE_BACK   = 3'd4;
    localparam logic [2:0] CURVE_SPRING = 3'd5;

    localparam logic REG_CURVE    = 1'b0;
    localparam logic REG_DURATION = 1'b1;

    localparam logic [2:0]  CURVE_RST    = 3'd0;
    localparam logic [23:0] DURATION_RST = 24'd19661;

    localparam logic [12:0] FRAME_MAX   = 13'd6554;
    localparam logic [23:0] DUR_MIN     = 24'd1966;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] HALF_Q16    = 17'd32768;
    localparam logic [17:0] TWO_Q16     = 18'd131072;
    localparam logic [17:0] BACK_C1     = 18'd111515;
    localparam logic [17:0] BACK_C3     = 18'd177051;
    localparam logic signed [32:0] SPRING_SNAP = 33'sd3277;
    localparam logic signed [32:0] EASE_SNAP   = 33'sd16384;
    localparam logic [35:0] OMEGA_NUM   = 36'h8_0000_0000;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_SWRD, ST_SWWR, ST_IDX, ST_RD, ST_CHK,
        ST_DIVS, ST_DIVW, ST_OMSQ, ST_KFS, ST_CDT, ST_KE, ST_CV, ST_DV,
        ST_NC, ST_SPFIN, ST_EX, ST_ESQ, ST_ECU, ST_EF, ST_EB1, ST_EB2,
        ST_EMUL, ST_EFIN, ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [31:0] r;
        if (x > 68'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -68'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/esva_mul.sv */
module esva_mul (
    input  logic                                 i_clk,
    input  logic signed [esva_pkg::MUL_W-1:0]    i_a,
    input  logic signed [esva_pkg::MUL_W-1:0]    i_b,
    output logic signed [esva_pkg::PROD_W-1:0]   o_p
);

    logic signed [esva_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* rtl/esva_div.sv */
module esva_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  esva_pkg::t_div_req            i_req,
    output logic [esva_pkg::DIV_NW-1:0]   o_quo,
    output logic                          o_done
);

    localparam int NW = esva_pkg::DIV_NW;
    localparam int DW = esva_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] w_rem;

    assign w_sh   = {r_rem, r_quo[NW-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_rem  = w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_rem;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

/* rtl/eased_spring_value_animator.sv */
// Channel  | Valid       | Stall        | Payload
// input    | i_valid     | o_in_stall   | i_command, i_frame_time, i_entry_index, i_target_value
// output   | o_out_valid | i_out_stall  | o_current_value
// config   | i_cfg_we    | -            | i_cfg_idx, i_cfg_data
// Begin and end frame sweep the mark table, reading and then writing back each entry.
// Animate reduces the index into the table, then reads and checks the entry; a new entry,
// or a settled one on an eased curve, goes straight to output. The spring, and an eased
// curve of nonzero duration, use the shared divider, then the single registered multiplier.
// After reset a clearing pass over the flag table runs before any item is taken.
// A result waits in its register while i_out_stall is high; no item is taken meanwhile.
module eased_spring_value_animator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_frame_time,
    input  logic [5:0]         i_entry_index,
    input  logic signed [31:0] i_target_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_current_value
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MW = esva_pkg::MUL_W;
    localparam int PW = esva_pkg::PROD_W;

    esva_pkg::t_state r_state, n_state;

    logic [2:0]         r_curve;
    logic [23:0]        r_dur;
    logic [12:0]        r_fs, n_fs;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_op, n_op;
    logic [5:0]         r_idx, n_idx;
    logic signed [31:0] r_tgt, n_tgt;
    logic signed [31:0] r_cur, n_cur;
    logic signed [31:0] r_vel, n_vel;
    logic signed [31:0] r_res, n_res;
    logic [24:0]        r_omega, n_omega;
    logic [16:0]        r_t, n_t;
    logic [16:0]        r_x, n_x;
    logic [32:0]        r_sq, n_sq;
    logic [28:0]        r_kdt, n_kdt;
    logic [22:0]        r_cdt, n_cdt;
    logic [17:0]        r_c3, n_c3;
    logic signed [18:0] r_f, n_f;
    logic signed [PW-1:0] r_acc, n_acc;

    logic [1:0]  flag_mem [TABLE_DEPTH];
    logic [63:0] data_mem [TABLE_DEPTH];
    logic [1:0]  r_flag_q;
    logic [63:0] r_data_q;

    logic        w_flag_we;
    logic [1:0]  w_flag_wd;
    logic        w_data_we;
    logic [63:0] w_data_wd;

    logic signed [MW-1:0] w_mul_a, w_mul_b;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_dvsum;
    logic signed [31:0]   w_nv, w_nc;
    logic signed [32:0]   w_err, w_nd;
    logic                 w_live;
    logic                 w_last;
    logic                 w_accept;
    logic                 w_snap_spring, w_snap_ease;

    esva_pkg::t_div_req        w_div_req;
    logic [esva_pkg::DIV_NW-1:0] w_quo;
    logic                      w_div_done;

    esva_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    esva_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    assign w_accept = i_valid && !o_in_stall;
    assign w_live   = r_flag_q[1];
    assign w_last   = r_addr == AW'(TABLE_DEPTH - 1);
    assign w_err    = 33'(r_tgt) - 33'(r_cur);
    assign w_dvsum  = r_acc - w_prod;
    assign w_nv     = esva_pkg::sat32(PW'(r_vel) + (w_dvsum >>> 16));
    assign w_nc     = esva_pkg::sat32(PW'(r_cur) + (w_prod >>> 16));
    assign w_nd     = 33'(r_tgt) - 33'(w_nc);
    assign w_snap_ease   = (w_nd > -esva_pkg::EASE_SNAP) && (w_nd < esva_pkg::EASE_SNAP);
    assign w_snap_spring = (w_nd > -esva_pkg::SPRING_SNAP) && (w_nd < esva_pkg::SPRING_SNAP)
                        && (33'(r_vel) > -esva_pkg::SPRING_SNAP)
                        && (33'(r_vel) < esva_pkg::SPRING_SNAP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            esva_pkg::ST_CLEAR: if (w_last) n_state = esva_pkg::ST_IDLE;
            esva_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        esva_pkg::CMD_BEGIN:   n_state = esva_pkg::ST_SWRD;
                        esva_pkg::CMD_END:     n_state = esva_pkg::ST_SWRD;
                        esva_pkg::CMD_ANIMATE: n_state = esva_pkg::ST_IDX;
                        default:               n_state = esva_pkg::ST_IDLE;
                    endcase
                end
            end
            esva_pkg::ST_SWRD: n_state = esva_pkg::ST_SWWR;
            esva_pkg::ST_SWWR: n_state = w_last ? esva_pkg::ST_IDLE : esva_pkg::ST_SWRD;
            esva_pkg::ST_IDX: begin
                if (int'(r_idx) < TABLE_DEPTH) n_state = esva_pkg::ST_RD;
            end
            esva_pkg::ST_RD: n_state = esva_pkg::ST_CHK;
            esva_pkg::ST_CHK: begin
                if (!w_live) begin
                    n_state = esva_pkg::ST_OUT;
                end else if (r_curve == esva_pkg::CURVE_SPRING) begin
                    n_state = esva_pkg::ST_DIVS;
                end else if (r_data_q[63:32] == r_tgt) begin
                    n_state = esva_pkg::ST_OUT;
                end else if (r_dur == '0) begin
                    n_state = esva_pkg::ST_EX;
                end else begin
                    n_state = esva_pkg::ST_DIVS;
                end
            end
            esva_pkg::ST_DIVS: n_state = esva_pkg::ST_DIVW;
            esva_pkg::ST_DIVW: begin
                if (w_div_done) begin
                    n_state = (r_curve == esva_pkg::CURVE_SPRING) ? esva_pkg::ST_OMSQ
                                                                  : esva_pkg::ST_EX;
                end
            end
            esva_pkg::ST_OMSQ:  n_state = esva_pkg::ST_KFS;
            esva_pkg::ST_KFS:   n_state = esva_pkg::ST_CDT;
            esva_pkg::ST_CDT:   n_state = esva_pkg::ST_KE;
            esva_pkg::ST_KE:    n_state = esva_pkg::ST_CV;
            esva_pkg::ST_CV:    n_state = esva_pkg::ST_DV;
            esva_pkg::ST_DV:    n_state = esva_pkg::ST_NC;
            esva_pkg::ST_NC:    n_state = esva_pkg::ST_SPFIN;
            esva_pkg::ST_SPFIN: n_state = esva_pkg::ST_OUT;
            esva_pkg::ST_EX: begin
                if (r_curve == esva_pkg::CURVE_IN || r_curve == esva_pkg::CURVE_OUT
                    || r_curve == esva_pkg::CURVE_INOUT || r_curve == esva_pkg::CURVE_BACK) begin
                    n_state = esva_pkg::ST_ESQ;
                end else begin
                    n_state = esva_pkg::ST_EMUL;
                end
            end
            esva_pkg::ST_ESQ: n_state = esva_pkg::ST_ECU;
            esva_pkg::ST_ECU: n_state = esva_pkg::ST_EF;
            esva_pkg::ST_EF: begin
                n_state = (r_curve == esva_pkg::CURVE_BACK) ? esva_pkg::ST_EB1
                                                            : esva_pkg::ST_EMUL;
            end
            esva_pkg::ST_EB1:  n_state = esva_pkg::ST_EB2;
            esva_pkg::ST_EB2:  n_state = esva_pkg::ST_EMUL;
            esva_pkg::ST_EMUL: n_state = esva_pkg::ST_EFIN;
            esva_pkg::ST_EFIN: n_state = esva_pkg::ST_OUT;
            esva_pkg::ST_OUT:  if (!i_out_stall) n_state = esva_pkg::ST_IDLE;
            default:           n_state = esva_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_fs    = r_fs;
        n_addr  = r_addr;
        n_op    = r_op;
        n_idx   = r_idx;
        n_tgt   = r_tgt;
        n_cur   = r_cur;
        n_vel   = r_vel;
        n_res   = r_res;
        n_omega = r_omega;
        n_t     = r_t;
        n_x     = r_x;
        n_sq    = r_sq;
        n_kdt   = r_kdt;
        n_cdt   = r_cdt;
        n_c3    = r_c3;
        n_f     = r_f;
        n_acc   = r_acc;
        w_flag_we = 1'b0;
        w_flag_wd = 2'b00;
        w_data_we = 1'b0;
        w_data_wd = {r_cur, r_vel};
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_div_req.start = 1'b0;
        w_div_req.num   = {7'd0, r_fs, 16'd0};
        w_div_req.den   = r_dur;
        if (r_curve == esva_pkg::CURVE_SPRING) begin
            w_div_req.num = esva_pkg::OMEGA_NUM;
            w_div_req.den = (r_dur < esva_pkg::DUR_MIN) ? esva_pkg::DUR_MIN : r_dur;
        end
        case (r_state)
            esva_pkg::ST_CLEAR: begin
                w_flag_we = 1'b1;
                n_addr    = r_addr + 1'b1;
            end
            esva_pkg::ST_IDLE: begin
                n_addr = '0;
                n_op   = i_command == esva_pkg::CMD_END;
                n_idx  = i_entry_index;
                n_tgt  = i_target_value;
                if (w_accept && i_command == esva_pkg::CMD_BEGIN) begin
                    n_fs = (i_frame_time > 16'(esva_pkg::FRAME_MAX)) ? esva_pkg::FRAME_MAX
                                                                      : i_frame_time[12:0];
                end
            end
            esva_pkg::ST_SWWR: begin
                w_flag_we = 1'b1;
                w_flag_wd = r_op ? {r_flag_q[1] & r_flag_q[0], r_flag_q[0]}
                                 : {r_flag_q[1], 1'b0};
                n_addr    = r_addr + 1'b1;
            end
            esva_pkg::ST_IDX: begin
                if (int'(r_idx) >= TABLE_DEPTH) begin
                    n_idx = r_idx - 6'(TABLE_DEPTH);
                end else begin
                    n_addr = AW'(r_idx);
                end
            end
            esva_pkg::ST_CHK: begin
                w_flag_we = 1'b1;
                w_flag_wd = 2'b11;
                n_cur = r_data_q[63:32];
                n_vel = r_data_q[31:0];
                n_res = r_data_q[63:32];
                n_t   = esva_pkg::ONE_Q16;
                if (!w_live) begin
                    w_data_we = 1'b1;
                    w_data_wd = {r_tgt, 32'd0};
                    n_res     = r_tgt;
                end
            end
            esva_pkg::ST_DIVS: w_div_req.start = 1'b1;
            esva_pkg::ST_DIVW: begin
                n_omega = w_quo[24:0];
                n_t = (w_quo > 36'(esva_pkg::ONE_Q16)) ? esva_pkg::ONE_Q16 : w_quo[16:0];
            end
            esva_pkg::ST_OMSQ: begin
                w_mul_a = MW'(r_omega);
                w_mul_b = MW'(r_omega);
            end
            esva_pkg::ST_KFS: begin
                w_mul_a = MW'(w_prod[48:16]);
                w_mul_b = MW'(r_fs);
            end
            esva_pkg::ST_CDT: begin
                n_kdt   = w_prod[44:16];
                w_mul_a = MW'({r_omega, 1'b0});
                w_mul_b = MW'(r_fs);
            end
            esva_pkg::ST_KE: begin
                n_cdt   = w_prod[38:16];
                w_mul_a = MW'(r_kdt);
                w_mul_b = MW'(w_err);
            end
            esva_pkg::ST_CV: begin
                n_acc   = w_prod;
                w_mul_a = MW'(r_cdt);
                w_mul_b = MW'(r_vel);
            end
            esva_pkg::ST_DV: n_vel = w_nv;
            esva_pkg::ST_NC: begin
                w_mul_a = MW'(r_vel);
                w_mul_b = MW'(r_fs);
            end
            esva_pkg::ST_SPFIN: begin
                w_data_we = 1'b1;
                if (w_snap_spring) begin
                    w_data_wd = {r_tgt, 32'd0};
                    n_res     = r_tgt;
                end else begin
                    w_data_wd = {w_nc, r_vel};
                    n_res     = w_nc;
                end
            end
            esva_pkg::ST_EX: begin
                n_f = 19'(r_t);
                case (r_curve)
                    esva_pkg::CURVE_IN: n_x = r_t;
                    esva_pkg::CURVE_INOUT: begin
                        n_x = (r_t < esva_pkg::HALF_Q16) ? r_t
                                                         : 17'(esva_pkg::TWO_Q16 - {r_t, 1'b0});
                    end
                    default: n_x = esva_pkg::ONE_Q16 - r_t;
                endcase
            end
            esva_pkg::ST_ESQ: begin
                w_mul_a = MW'(r_x);
                w_mul_b = MW'(r_x);
            end
            esva_pkg::ST_ECU: begin
                n_sq    = w_prod[32:0];
                w_mul_a = MW'(w_prod[32:0]);
                w_mul_b = MW'(r_x);
            end
            esva_pkg::ST_EF: begin
                w_mul_a = MW'(esva_pkg::BACK_C3);
                w_mul_b = MW'(w_prod[48:32]);
                case (r_curve)
                    esva_pkg::CURVE_IN: n_f = 19'({2'b00, w_prod[48:32]});
                    esva_pkg::CURVE_OUT: begin
                        n_f = 19'({2'b00, esva_pkg::ONE_Q16}) - 19'({2'b00, w_prod[48:32]});
                    end
                    esva_pkg::CURVE_INOUT: begin
                        if (r_t < esva_pkg::HALF_Q16) begin
                            n_f = 19'({2'b00, w_prod[46:30]});
                        end else begin
                            n_f = 19'({2'b00, esva_pkg::ONE_Q16})
                                - 19'({2'b00, w_prod[49:33]});
                        end
                    end
                    default: n_f = r_f;
                endcase
            end
            esva_pkg::ST_EB1: begin
                n_c3    = w_prod[33:16];
                w_mul_a = MW'(esva_pkg::BACK_C1);
                w_mul_b = MW'(r_sq[32:16]);
            end
            esva_pkg::ST_EB2: begin
                n_f = 19'({2'b00, esva_pkg::ONE_Q16}) - 19'({1'b0, r_c3})
                    + 19'({1'b0, w_prod[33:16]});
            end
            esva_pkg::ST_EMUL: begin
                w_mul_a = MW'(w_err);
                w_mul_b = MW'(r_f);
            end
            esva_pkg::ST_EFIN: begin
                w_data_we = 1'b1;
                if (w_snap_ease) begin
                    w_data_wd = {r_tgt, r_vel};
                    n_res     = r_tgt;
                end else begin
                    w_data_wd = {w_nc, r_vel};
                    n_res     = w_nc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esva_pkg::ST_CLEAR;
            r_addr  <= '0;
            r_curve <= esva_pkg::CURVE_RST;
            r_dur   <= esva_pkg::DURATION_RST;
            r_fs    <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_fs    <= n_fs;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    esva_pkg::REG_CURVE:    r_curve <= i_cfg_data[2:0];
                    esva_pkg::REG_DURATION: r_dur   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_idx   <= n_idx;
        r_tgt   <= n_tgt;
        r_cur   <= n_cur;
        r_vel   <= n_vel;
        r_res   <= n_res;
        r_omega <= n_omega;
        r_t     <= n_t;
        r_x     <= n_x;
        r_sq    <= n_sq;
        r_kdt   <= n_kdt;
        r_cdt   <= n_cdt;
        r_c3    <= n_c3;
        r_f     <= n_f;
        r_acc   <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (w_flag_we) flag_mem[r_addr] <= w_flag_wd;
        if (w_data_we) data_mem[r_addr] <= w_data_wd;
        r_flag_q <= flag_mem[r_addr];
        r_data_q <= data_mem[r_addr];
    end

    assign o_in_stall      = r_state != esva_pkg::ST_IDLE;
    assign o_out_valid     = r_state == esva_pkg::ST_OUT;
    assign o_current_value = r_res;

    a_no_take_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !o_out_valid)
        else $error("item taken while a result is pending");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == esva_pkg::ST_RD |-> int'(r_addr) < TABLE_DEPTH)
        else $error("slot index not reduced into the table");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == esva_pkg::ST_DIVW)
        else $error("divider finished outside its wait state");

    a_div_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> r_state == esva_pkg::ST_DIVW && !w_div_done)
        else $error("divider start not followed by wait");

endmodule

/* bench/tb_eased_spring_value_animator.sv */
`timescale 1ns / 1ps

module tb_eased_spring_value_animator;

    localparam logic [1:0] CMD_NONE     = 2'd3;
    localparam int         IDLE_LIMIT   = 20000;
    localparam int         SETTLE       = 300;

    class value_scoreboard;
        int          cur_q[64];
        int          tgt_q[64];
        int          vel_q[64];
        bit [63:0]   live;
        bit [63:0]   seen;
        longint      frame_step;
        logic [2:0]  curve;
        longint      duration;
        int          expected_values[$];
        int          errors;

        function new();
            live = '0;
            seen = '0;
            frame_step = 0;
            curve = esva_pkg::CURVE_RST;
            duration = longint'(esva_pkg::DURATION_RST);
            errors = 0;
        endfunction

        function void set_reg(logic idx, logic [23:0] data);
            if (idx == esva_pkg::REG_CURVE) begin
                curve = data[2:0];
            end else begin
                duration = longint'(data);
            end
        endfunction

        function int sat(longint x);
            if (x > 64'sd2147483647) begin
                return 32'sh7FFF_FFFF;
            end
            if (x < -64'sd2147483648) begin
                return 32'sh8000_0000;
            end
            return int'(x);
        endfunction

        function longint mag(longint x);
            return x < 0 ? -x : x;
        endfunction

        function longint shape(longint t);
            longint m, w, m3, m2;
            case (curve)
                esva_pkg::CURVE_IN: return (t * t * t) >> 32;
                esva_pkg::CURVE_OUT: begin
                    m = 65536 - t;
                    return 65536 - ((m * m * m) >> 32);
                end
                esva_pkg::CURVE_INOUT: begin
                    if (t < 32768) begin
                        return (4 * t * t * t) >> 32;
                    end
                    w = 131072 - 2 * t;
                    return 65536 - ((w * w * w) >> 33);
                end
                esva_pkg::CURVE_BACK: begin
                    m = 65536 - t;
                    m3 = (m * m * m) >> 32;
                    m2 = (m * m) >> 16;
                    return 65536 - ((177051 * m3) >> 16) + ((111515 * m2) >> 16);
                end
                default: return t;
            endcase
        endfunction

        function int spring(int i);
            longint d, omega, k, kdt, cdt, err, v, dv;
            int nv, nc;
            d = duration < 1966 ? 1966 : duration;
            omega = (64'sd1 << 35) / d;
            k = (omega * omega) >> 16;
            kdt = (k * frame_step) >> 16;
            cdt = (2 * omega * frame_step) >> 16;
            err = longint'(tgt_q[i]) - longint'(cur_q[i]);
            v = vel_q[i];
            dv = (kdt * err - cdt * v) >>> 16;
            nv = sat(v + dv);
            nc = sat(longint'(cur_q[i]) + ((longint'(nv) * frame_step) >>> 16));
            vel_q[i] = nv;
            cur_q[i] = nc;
            if (mag(longint'(tgt_q[i]) - longint'(nc)) < 3277 && mag(longint'(nv)) < 3277) begin
                cur_q[i] = tgt_q[i];
                vel_q[i] = 0;
            end
            return cur_q[i];
        endfunction

        function int ease(int i);
            longint step, f, diff;
            if (cur_q[i] == tgt_q[i]) begin
                return cur_q[i];
            end
            if (duration == 0) begin
                step = 65536;
            end else begin
                step = (frame_step << 16) / duration;
                if (step > 65536) begin
                    step = 65536;
                end
            end
            f = shape(step);
            diff = longint'(tgt_q[i]) - longint'(cur_q[i]);
            cur_q[i] = sat(longint'(cur_q[i]) + ((diff * f) >>> 16));
            if (mag(longint'(tgt_q[i]) - longint'(cur_q[i])) < 16384) begin
                cur_q[i] = tgt_q[i];
            end
            return cur_q[i];
        endfunction

        function void note_item(logic [1:0] cmd, logic [15:0] ft, logic [5:0] idx, int tgt);
            case (cmd)
                esva_pkg::CMD_BEGIN: begin
                    frame_step = (ft > 16'd6554) ? 64'sd6554 : longint'(ft);
                    seen = '0;
                end
                esva_pkg::CMD_END: live = live & seen;
                esva_pkg::CMD_ANIMATE: begin
                    seen[idx] = 1'b1;
                    if (!live[idx]) begin
                        cur_q[idx] = tgt;
                        tgt_q[idx] = tgt;
                        vel_q[idx] = 0;
                        live[idx] = 1'b1;
                        expected_values.push_back(tgt);
                    end else begin
                        tgt_q[idx] = tgt;
                        expected_values.push_back(curve == esva_pkg::CURVE_SPRING ? spring(idx)
                                                                                 : ease(idx));
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_value(int actual);
            int want;
            if (expected_values.size() == 0) begin
                $error("current_value: nothing expected, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (want != actual) begin
                $error("current_value: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_command = '0;
    logic [15:0]        i_frame_time = '0;
    logic [5:0]         i_entry_index = '0;
    logic signed [31:0] i_target_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_current_value;

    value_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  send_burst = 0;
    bit  drain_burst = 0;
    int  slot_target[64];

    eased_spring_value_animator dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_value(o_current_value);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                drain_burst = !drain_burst;
            end
            n = drain_burst ? 0 : $urandom_range(0, 18);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic write_reg(logic idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic send_item(logic [1:0] cmd, logic [15:0] ft, logic [5:0] idx, int tgt);
        int gap;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_frame_time <= ft;
        i_entry_index <= idx;
        i_target_value <= tgt;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(cmd, ft, idx, tgt);
        if (cmd == esva_pkg::CMD_ANIMATE) begin
            slot_target[idx] = tgt;
        end
        if ($urandom_range(0, 29) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_values.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic int next_target(int slot);
        int r;
        longint t;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return int'($urandom());
        end
        if (r < 14) begin
            return r[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        if (r < 24) begin
            return slot_target[slot];
        end
        t = longint'(slot_target[slot]) + ($signed($urandom()) >>> $urandom_range(6, 30));
        return sb.sat(t);
    endfunction

    initial begin
        int k;
        int slot;
        int base;
        int pool;
        logic [15:0] ft;
        logic [23:0] dur;
        foreach (slot_target[j]) slot_target[j] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(esva_pkg::CMD_BEGIN, 16'hFFFF, '0, 0);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd0, 32'sh7FFF_FFFF);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd63, 32'sh8000_0000);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd5, 0);
        send_item(esva_pkg::CMD_END, '0, '0, 0);
        send_item(esva_pkg::CMD_BEGIN, 16'd6554, '0, 0);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd0, 32'sh8000_0000);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd63, 32'sh7FFF_FFFF);
        send_item(CMD_NONE, 16'hFFFF, 6'h3F, -1);
        send_item(esva_pkg::CMD_END, '0, '0, 0);
        send_item(esva_pkg::CMD_BEGIN, 16'd0, '0, 0);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd63, 0);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd5, 1000);
        send_item(esva_pkg::CMD_END, '0, '0, 0);
        send_item(esva_pkg::CMD_BEGIN, 16'd6555, '0, 0);
        send_item(esva_pkg::CMD_ANIMATE, '0, 6'd5, 32'sh7FFF_FFFF);
        send_item(esva_pkg::CMD_END, '0, '0, 0);
        drain();

        for (int p = 0; p < 16; p++) begin
            case (p % 6)
                0: dur = 24'd0;
                1: dur = 24'hFF_FFFF;
                2: dur = 24'd1966;
                3: dur = 24'd1;
                4: dur = 24'd19661;
                default: dur = 24'($urandom_range(1000, 120000));
            endcase
            write_reg(esva_pkg::REG_CURVE, 24'(p % 8));
            write_reg(esva_pkg::REG_DURATION, dur);
            base = $urandom_range(0, 63);
            pool = $urandom_range(2, 10);
            k = 0;
            while (k < 90) begin
                ft = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6554));
                send_item(esva_pkg::CMD_BEGIN, ft, 6'($urandom()), int'($urandom()));
                k++;
                for (int a = $urandom_range(1, 8); a > 0; a--) begin
                    slot = (base + $urandom_range(0, pool - 1)) % 64;
                    send_item(esva_pkg::CMD_ANIMATE, 16'($urandom()), 6'(slot),
                              next_target(slot));
                    k++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_item(CMD_NONE, 16'($urandom()), 6'($urandom()), int'($urandom()));
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(esva_pkg::CMD_END, 16'($urandom()), 6'($urandom()),
                              int'($urandom()));
                    k++;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_values.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
